// ===== rtl/chs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chs_pkg: shared types and constants for the chained hash set
// operation codes, error codes, sequencer states, defaults
// ----------------------------------------------------------------------------
package chs_pkg;

	localparam int BUCKETS_DEF    = 64;
	localparam int POOL_NODES_DEF = 256;
	localparam int KEY_BYTES_DEF  = 8;
	localparam int KEY_W          = 64;

	typedef enum logic [1:0] {
		OP_ADD      = 2'd0,
		OP_REMOVE   = 2'd1,
		OP_CONTAINS = 2'd2,
		OP_CLEAR    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ERR_NONE = 2'd0,
		ERR_FULL = 2'd1,
		ERR_ZERO = 2'd2
	} err_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_HEAD_RD,
		ST_HEAD_CHK,
		ST_NODE_RD,
		ST_NODE_CHK,
		ST_FREE_RD,
		ST_FREE_CHK,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/chained_hash_set.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_set: set of nonzero 64-bit keys with separate chaining
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one operation per transfer: tuser = op, tdata = key.
//   m_axis returns one result per operation: tdata = {error, answer}.
//   one operation at a time: s_axis_tready is low from acceptance until the
//   result leaves the output register.
// sequencing, over the single-port head memory and node memory:
//   add/remove/contains: the head is read and checked, then each chained
//   node is read and checked in turn; an add may pop a free-list node, and
//   removing a node that follows another node rewrites the predecessor link
//   and then frees the node. a zero key is answered without a memory read.
//   clear: head valid bits cleared at once.
// reset: all buckets empty, free list empty, fresh count zero. head valid
//   bits clear at once, so no clearing pass follows reset.
// stall: a result waits in the output register while m_axis_tready is low;
//   no new operation is accepted meanwhile.
// ----------------------------------------------------------------------------
module chained_hash_set #(
	parameter int BUCKETS    = chs_pkg::BUCKETS_DEF,
	parameter int POOL_NODES = chs_pkg::POOL_NODES_DEF,
	parameter int KEY_BYTES  = chs_pkg::KEY_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // [63:0] key
	input  logic [1:0]  s_axis_tuser,  // [1:0] op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata   // [0] answer, [2:1] error, zero fill
);
	import chs_pkg::*;

	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int NW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
	localparam int LW = $clog2(POOL_NODES + 1);
	localparam logic [LW-1:0] LNULL = LW'(POOL_NODES);
	localparam int EW = KEY_W + LW;
	// reciprocal for the bucket remainder, exact for 8-bit operands
	localparam int BMUL = (65536 + BUCKETS - 1) / BUCKETS;

	state_t state_q, state_nx;
	op_t         op_q;
	logic [63:0] key_q;
	logic [63:0] pkey_q;
	logic [BW-1:0] bkt_q;
	logic [LW-1:0] cur_q, prev_q, free_q, fresh_q, node_q;
	logic [BUCKETS-1:0] hvalid_q;
	logic          ans_q;
	err_t          err_q;
	logic          ovalid_q;

	// head memory (key, link) and node memory (key, link)
	logic          h_we, n_we;
	logic [BW-1:0] h_addr;
	logic [NW-1:0] n_addr;
	logic [EW-1:0] h_wd, h_rd, n_wd, n_rd;

	chs_ram #(.WIDTH(EW), .DEPTH(BUCKETS)) u_head (
		.clk(clk), .we(h_we), .addr(h_addr), .wdata(h_wd), .rdata(h_rd)
	);
	chs_ram #(.WIDTH(EW), .DEPTH(POOL_NODES)) u_node (
		.clk(clk), .we(n_we), .addr(n_addr), .wdata(n_wd), .rdata(n_rd)
	);

	logic [63:0] hk, nk;
	logic [LW-1:0] hl, nl;
	assign hk = hvalid_q[bkt_q] ? h_rd[EW-1:LW] : '0;
	assign hl = hvalid_q[bkt_q] ? h_rd[LW-1:0] : LNULL;
	assign nk = n_rd[EW-1:LW];
	assign nl = n_rd[LW-1:0];

	function automatic logic [BW-1:0] bucket_of(logic [63:0] k);
		logic [7:0] acc;
		logic [23:0] prod;
		logic [15:0] rem;
		acc = '0;
		for (int i = 0; i < KEY_BYTES; i++) begin
			acc = acc ^ k[8*i +: 8];
		end
		prod = 24'(acc) * 24'(BMUL);
		rem = 16'(acc) - 16'(prod[23:16]) * 16'(BUCKETS);
		return BW'(rem);
	endfunction

	logic accept;
	assign s_axis_tready = (state_q == ST_IDLE) && !ovalid_q;
	assign accept = s_axis_tvalid && s_axis_tready;

	// control
	logic set_res, clr_valid, pkey_ld;
	logic ans_d;
	err_t err_d;
	logic [LW-1:0] cur_d, prev_d, free_d, fresh_d, node_d;
	logic [BW-1:0] bkt_d;

	always_comb begin
		state_nx = state_q;
		h_we = 1'b0; n_we = 1'b0;
		h_addr = bkt_q; n_addr = NW'(cur_q);
		h_wd = '0; n_wd = '0;
		set_res = 1'b0; ans_d = 1'b0; err_d = ERR_NONE;
		clr_valid = 1'b0; pkey_ld = 1'b0;
		cur_d = cur_q; prev_d = prev_q; free_d = free_q; fresh_d = fresh_q;
		node_d = node_q; bkt_d = bkt_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					bkt_d = bucket_of(s_axis_tdata);
					if (op_t'(s_axis_tuser) == OP_CLEAR) begin
						bkt_d = '0;
						state_nx = ST_CLEAR;
					end else if (s_axis_tdata == '0) begin
						set_res = 1'b1; err_d = ERR_ZERO;
					end else begin
						state_nx = ST_HEAD_RD;
					end
				end
			end
			ST_CLEAR: begin
				clr_valid = 1'b1;
				free_d = LNULL; fresh_d = '0;
				set_res = 1'b1;
				state_nx = ST_IDLE;
			end
			ST_HEAD_RD: begin
				state_nx = ST_HEAD_CHK;
			end
			ST_HEAD_CHK: begin
				cur_d = hl; prev_d = LNULL;
				if (op_q == OP_ADD && hk == '0) begin
					h_we = 1'b1; h_wd = {key_q, hl};
					set_res = 1'b1; ans_d = 1'b1; state_nx = ST_IDLE;
				end else if (hk == key_q) begin
					set_res = 1'b1;
					ans_d = (op_q != OP_ADD);
					if (op_q == OP_REMOVE) begin
						if (hl == LNULL) begin
							h_we = 1'b1; h_wd = {64'd0, LNULL}; state_nx = ST_IDLE;
						end else begin
							// pull first chained node into the head
							set_res = 1'b0; node_d = hl; state_nx = ST_NODE_RD;
						end
					end else begin
						state_nx = ST_IDLE;
					end
				end else if (hl == LNULL) begin
					state_nx = ST_NODE_CHK;
				end else begin
					state_nx = ST_NODE_RD;
				end
			end
			ST_NODE_RD: begin
				n_addr = NW'(cur_q);
				state_nx = ST_NODE_CHK;
			end
			ST_NODE_CHK: begin
				if (node_q != LNULL && op_q == OP_REMOVE) begin
					// head removal: node cur_q moves into head, node freed
					h_we = 1'b1; h_wd = {nk, nl};
					n_we = 1'b1; n_wd = {64'd0, free_q};
					free_d = cur_q; node_d = LNULL;
					set_res = 1'b1; ans_d = 1'b1; state_nx = ST_IDLE;
				end else if (cur_q != LNULL && nk == key_q) begin
					set_res = 1'b1;
					ans_d = (op_q != OP_ADD);
					state_nx = ST_IDLE;
					if (op_q == OP_REMOVE) begin
						// unlink: rewrite predecessor link, then free node
						if (prev_q == LNULL) begin
							h_we = 1'b1; h_wd = {hk, nl};
							n_we = 1'b1; n_wd = {64'd0, free_q};
							free_d = cur_q;
						end else begin
							set_res = 1'b0; node_d = nl; state_nx = ST_FREE_RD;
						end
					end
				end else if (cur_q != LNULL) begin
					pkey_ld = 1'b1;
					prev_d = cur_q; cur_d = nl; state_nx = ST_NODE_RD;
					if (nl == LNULL) state_nx = ST_NODE_CHK;
				end else if (op_q == OP_ADD) begin
					if (free_q != LNULL) begin
						n_addr = NW'(free_q); state_nx = ST_FREE_CHK;
					end else if (fresh_q < LNULL) begin
						n_we = 1'b1; n_addr = NW'(fresh_q); n_wd = {key_q, hl};
						h_we = 1'b1; h_wd = {hk, fresh_q};
						fresh_d = fresh_q + 1'b1;
						set_res = 1'b1; ans_d = 1'b1; state_nx = ST_IDLE;
					end else begin
						set_res = 1'b1; err_d = ERR_FULL; state_nx = ST_IDLE;
					end
				end else begin
					set_res = 1'b1; state_nx = ST_IDLE;
				end
			end
			ST_FREE_RD: begin
				// write prev link here; ST_DONE then frees cur
				n_we = 1'b1; n_addr = NW'(prev_q); n_wd = {pkey_q, node_q};
				state_nx = ST_DONE;
			end
			ST_DONE: begin
				n_we = 1'b1; n_addr = NW'(cur_q); n_wd = {64'd0, free_q};
				free_d = cur_q; node_d = LNULL;
				set_res = 1'b1; ans_d = 1'b1; state_nx = ST_IDLE;
			end
			ST_FREE_CHK: begin
				// nl holds popped free node's link
				n_we = 1'b1; n_addr = NW'(free_q); n_wd = {key_q, hl};
				h_we = 1'b1; h_wd = {hk, free_q};
				free_d = nl;
				set_res = 1'b1; ans_d = 1'b1; state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// key of the predecessor node, kept for the link rewrite
	always_ff @(posedge clk) begin
		if (pkey_ld) pkey_q <= nk;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			hvalid_q <= '0;
			free_q   <= LNULL;
			fresh_q  <= '0;
			ovalid_q <= 1'b0;
			node_q   <= LNULL;
		end else begin
			state_q <= state_nx;
			free_q  <= free_d;
			fresh_q <= fresh_d;
			node_q  <= node_d;
			if (clr_valid) hvalid_q <= '0;
			else if (h_we) hvalid_q[bkt_q] <= 1'b1;
			if (set_res) ovalid_q <= 1'b1;
			else if (m_axis_tready) ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		cur_q  <= cur_d;
		prev_q <= prev_d;
		bkt_q  <= bkt_d;
		if (accept) begin
			op_q  <= op_t'(s_axis_tuser);
			key_q <= s_axis_tdata;
		end
		if (set_res) begin
			ans_q <= ans_d;
			err_q <= err_d;
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = {5'd0, err_q, ans_q};

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !s_axis_tready)
		else $error("ready while busy");
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= LNULL)
		else $error("free head out of range");
	a_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q <= LNULL)
		else $error("fresh count overflow");
	a_clr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |=> hvalid_q == '0)
		else $error("clear left heads valid");

endmodule

// ===== rtl/chs_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chs_ram: generic single-port ram
// one access a cycle: read every cycle, written when we is set, registered read data
// ----------------------------------------------------------------------------
module chs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ===== sim/chained_hash_set_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_set_tb: self-checking bench for the chained hash set
// drives add/remove/contains/clear transfers with random gaps and stalls,
// predicts each answer and error with a behavioral hash set of its own
// ----------------------------------------------------------------------------
module chained_hash_set_tb;
	import chs_pkg::*;

	localparam int NB = 64;
	localparam int NP = 256;
	localparam logic [8:0] NIL = 9'(NP);

	typedef struct packed {
		logic       answer;
		err_t       error;
	} outcome_t;

	class set_scoreboard;
		logic [63:0] hkey[NB];
		logic [8:0]  hlink[NB];
		logic [63:0] nkey[NP];
		logic [8:0]  nlink[NP];
		logic [8:0]  free_top;
		int          fresh;
		outcome_t    pending[$];
		int          errors;

		function new();
			errors = 0;
			for (int i = 0; i < NB; i++) begin
				hkey[i] = '0;
				hlink[i] = NIL;
			end
			free_top = NIL;
			fresh = 0;
		endfunction

		function int bucket(logic [63:0] k);
			logic [7:0] acc;
			acc = '0;
			for (int i = 0; i < 8; i++) acc ^= k[8*i +: 8];
			return int'(acc) % NB;
		endfunction

		function bit holds(int b, logic [63:0] k);
			logic [8:0] n;
			n = hlink[b];
			if (hkey[b] == k) return 1;
			for (int s = 0; s < NP && n < NIL; s++) begin
				if (nkey[n] == k) return 1;
				n = nlink[n];
			end
			return 0;
		endfunction

		function void note_op(op_t op, logic [63:0] k);
			outcome_t r;
			int b;
			logic [8:0] n, prev;
			r.answer = 0;
			r.error = ERR_NONE;
			b = bucket(k);
			if (op == OP_CLEAR) begin
				for (int i = 0; i < NB; i++) begin
					hkey[i] = '0;
					hlink[i] = NIL;
				end
				free_top = NIL;
				fresh = 0;
			end else if (k == 0) begin
				r.error = ERR_ZERO;
			end else if (op == OP_ADD) begin
				if (hkey[b] == 0) begin
					hkey[b] = k;
					r.answer = 1;
				end else if (!holds(b, k)) begin
					n = NIL;
					if (free_top < NIL) begin
						n = free_top;
						free_top = nlink[n];
					end else if (fresh < NP) begin
						n = 9'(fresh);
						fresh++;
					end
					if (n < NIL) begin
						nkey[n] = k;
						nlink[n] = hlink[b];
						hlink[b] = n;
						r.answer = 1;
					end else r.error = ERR_FULL;
				end
			end else if (op == OP_CONTAINS) begin
				r.answer = holds(b, k);
			end else if (hkey[b] == k) begin
				r.answer = 1;
				n = hlink[b];
				if (n < NIL) begin
					hkey[b] = nkey[n];
					hlink[b] = nlink[n];
					nlink[n] = free_top;
					free_top = n;
				end else begin
					hkey[b] = '0;
					hlink[b] = NIL;
				end
			end else begin
				prev = NIL;
				n = hlink[b];
				for (int s = 0; s < NP && n < NIL; s++) begin
					if (nkey[n] == k) begin
						if (prev < NIL) nlink[prev] = nlink[n];
						else hlink[b] = nlink[n];
						nlink[n] = free_top;
						free_top = n;
						r.answer = 1;
						break;
					end
					prev = n;
					n = nlink[n];
				end
			end
			pending.push_back(r);
		endfunction

		function void check_result(logic [7:0] d);
			outcome_t e;
			if (pending.size() == 0) begin
				$display("%0t unexpected result: expected none, actual %h", $time, d);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (d[0] !== e.answer) begin
				$display("%0t answer mismatch: expected %0d, actual %0d", $time,
					e.answer, d[0]);
				errors++;
			end
			if (d[2:1] !== e.error) begin
				$display("%0t error mismatch: expected %0d, actual %0d", $time,
					e.error, d[2:1]);
				errors++;
			end
			if (d[7:3] !== 5'd0) begin
				$display("%0t fill mismatch: expected 0, actual %h", $time, d[7:3]);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;

	set_scoreboard sb;
	bit            stim_done;
	bit            long_hold;
	logic [63:0]   recent[$];

	chained_hash_set dut (.*);

	initial clk = 0;
	always #4 clk = ~clk;

	// one operation per call, with a random gap before it
	task automatic send_op(op_t op, logic [63:0] k);
		int gap;
		gap = $urandom_range(0, 7);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			s_axis_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= op;
		s_axis_tdata <= k;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_op(op, k);
	endtask

	// keys that crowd buckets 0 to 43 so chains form; some random or zero
	function automatic logic [63:0] pick_key();
		logic [63:0] k;
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 4 && recent.size() > 0)
			k = recent[$urandom_range(0, recent.size() - 1)];
		else if (sel < 7)
			k = {56'($urandom_range(0, 40)), 8'($urandom_range(0, 3))};
		else if (sel == 7)
			k = 64'd0;
		else
			k = {$urandom, $urandom};
		return k;
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
	end

	// receiver stalls, with one long hold-off to back up the input
	initial begin
		int w;
		m_axis_tready <= 0;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				m_axis_tready <= 0;
				repeat (300) @(posedge clk);
				long_hold = 0;
			end
			w = $urandom_range(0, 7);
			if ($urandom_range(0, 3) == 0) w = 0;
			if (w > 0) begin
				m_axis_tready <= 0;
				repeat (w) @(posedge clk);
			end
			m_axis_tready <= 1;
			@(posedge clk);
		end
	end

	initial begin
		op_t op;
		logic [63:0] k;
		sb = new();
		stim_done = 0;
		long_hold = 0;
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		s_axis_tuser = OP_ADD;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: zero key, extremes, head/chain removal, clear
		send_op(OP_ADD, 64'd0);
		send_op(OP_REMOVE, 64'd0);
		send_op(OP_CONTAINS, 64'd0);
		send_op(OP_ADD, '1);
		send_op(OP_ADD, '1);
		send_op(OP_CONTAINS, '1);
		send_op(OP_ADD, 64'h0101);
		send_op(OP_ADD, 64'h0202);
		send_op(OP_ADD, 64'h0303);
		send_op(OP_CONTAINS, 64'h0202);
		send_op(OP_REMOVE, 64'h0202);
		send_op(OP_REMOVE, 64'h0101);
		send_op(OP_REMOVE, 64'h0101);
		send_op(OP_CONTAINS, 64'h0303);
		send_op(OP_ADD, 64'h8000_0000_0000_0000);
		send_op(OP_CLEAR, 64'h0);
		send_op(OP_CONTAINS, '1);
		send_op(OP_REMOVE, 64'h0303);
		// fill the pool: 258 keys into bucket 0 (the last finds it full), then one more
		for (int i = 1; i <= 258; i++) send_op(OP_ADD, {32'(i), 32'(i)});
		send_op(OP_ADD, {32'd1, 32'd1});
		send_op(OP_REMOVE, {32'd5, 32'd5});
		send_op(OP_ADD, {32'd300, 32'd300});
		send_op(OP_CLEAR, '1);

		for (int i = 0; i < 2000; i++) begin
			if (i == 500) long_hold = 1;
			if ($urandom_range(0, 199) == 0) op = OP_CLEAR;
			else op = op_t'($urandom_range(0, 2));
			k = pick_key();
			if (op == OP_ADD && k != 0) begin
				recent.push_back(k);
				if (recent.size() > 64) void'(recent.pop_front());
			end
			send_op(op, k);
		end
		s_axis_tvalid <= 0;
		stim_done = 1;
	end

	initial begin
		wait (stim_done);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.errors == 0) $display("PASS chained_hash_set");
		else $display("FAIL chained_hash_set");
		$finish;
	end

	initial begin
		#100ms;
		$display("FAIL chained_hash_set");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/chs_pkg.sv
rtl/chs_ram.sv
rtl/chained_hash_set.sv
sim/chained_hash_set_tb.sv
